// File: hw/rtl/gjk_css_pkg.sv
package gjk_css_pkg;

    localparam int KIND_W = 2;
    localparam int VEC_W  = 63;
    localparam int IDX_W  = 2;

    // simplex kind codes on the input side
    localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEGMENT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TETRA    = 2'd3;

    // kept kind codes on the result side
    localparam logic [KIND_W-1:0] KEPT_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KEPT_POINT    = 2'd1;
    localparam logic [KIND_W-1:0] KEPT_SEGMENT  = 2'd2;
    localparam logic [KIND_W-1:0] KEPT_TRIANGLE = 2'd3;

    // tetrahedron faces
    localparam logic [1:0] FACE_ABC = 2'd0;
    localparam logic [1:0] FACE_ACD = 2'd1;
    localparam logic [1:0] FACE_ADB = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] simplex_kind;
        logic [VEC_W-1:0]  newest_point;
        logic [VEC_W-1:0]  edge_ab;
        logic [VEC_W-1:0]  edge_ac;
        logic [VEC_W-1:0]  edge_ad;
    } in_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] kept_kind;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic [IDX_W-1:0]  third_index;
    } out_beat_t;

    // sign flags that ride along with a beat down the pipeline
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [2:0]        eo_nn;   // edge . ao >= 0, per edge ab/ac/ad
        logic [2:0]        t1_nn;   // (n x e2) . ao >= 0, per face
        logic [2:0]        t2_nn;   // (e1 x n) . ao >= 0, per face
        logic [2:0]        d_neg;   // n . ao < 0, per face
        logic [2:0]        gt;      // abc>acd, abc>adb, acd>adb
    } ctrl_t;

endpackage

// File: hw/rtl/gjk_css_smul.sv
module gjk_css_smul #(
    parameter int WA = 22,
    parameter int WB = 22
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int CH = 32;
    localparam int NA = (WA + CH - 1) / CH;
    localparam int NB = (WB + CH - 1) / CH;
    localparam int WP = WA + WB;
    localparam int WS = (NA + NB) * CH;

    logic [WA-1:0]        abs_a;
    logic [WB-1:0]        abs_b;
    logic [NA*CH-1:0]     mag_a_reg, mag_a_next;
    logic [NB*CH-1:0]     mag_b_reg, mag_b_next;
    logic                 s1_reg, s2_reg, s3_reg;
    logic [2*CH-1:0]      pp_reg  [NA][NB];
    logic [2*CH-1:0]      pp_next [NA][NB];
    logic [WS-1:0]        acc;
    logic [WP-1:0]        prod_reg, prod_next;
    logic signed [WP-1:0] p_reg, p_next;

    // stage 1: sign and magnitude
    always_comb begin
        abs_a = a[WA-1] ? WA'(-a) : WA'(a);
        abs_b = b[WB-1] ? WB'(-b) : WB'(b);
        mag_a_next = (NA*CH)'(abs_a);
        mag_b_next = (NB*CH)'(abs_b);
    end

    // stage 2: 32x32 partial products
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_next[i][j] = mag_a_reg[i*CH +: CH] * mag_b_reg[j*CH +: CH];
            end
        end
    end

    // stage 3: sum of shifted partials
    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (WS'(pp_reg[i][j]) << ((i + j) * CH));
            end
        end
        prod_next = acc[WP-1:0];
    end

    // stage 4: restore sign
    always_comb begin
        p_next = s3_reg ? -signed'(prod_reg) : signed'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            s1_reg    <= a[WA-1] ^ b[WB-1];
            pp_reg    <= pp_next;
            s2_reg    <= s1_reg;
            prod_reg  <= prod_next;
            s3_reg    <= s2_reg;
            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/gjk_css_dly.sv
module gjk_css_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

// File: hw/rtl/gjk_closest_subsimplex_select.sv
// GJK sub-simplex selector. Each beat carries a simplex kind, the newest vertex A and the edge
// vectors AB, AC, AD; the result beat names the sub-simplex nearest the origin. All tests are
// exact integer sign tests, and tetrahedron faces are ranked by d*|d|/|N|^2 through
// cross-multiplication. The block is a 21-stage pipeline built from four rounds of
// multiplication (edge products, normal and face-test products, d squared, cross-multiplied
// distances), each round a pipelined multiplier that splits its operands into 32-bit chunks
// for 32x32 partial products, plus five register stages for sums, magnitudes, compares and the
// final decision. A beat is accepted every cycle while the pipeline is not held; when the output
// beat is not taken the whole pipeline holds, so s_ready follows m_ready in that case.
module gjk_closest_subsimplex_select #(
    parameter int COMPONENT_BITS = 21
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  gjk_css_pkg::in_beat_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output gjk_css_pkg::out_beat_t m_data
);

    import gjk_css_pkg::*;

    localparam int C     = COMPONENT_BITS;
    localparam int WO    = C + 1;          // edge / ao operand
    localparam int WPA   = 2 * WO;
    localparam int WD    = 2 * C + 1;      // dots and normal components
    localparam int WPBD  = WD + WO;
    localparam int WDD   = 3 * C + 1;      // n . ao
    localparam int WPB   = 2 * WD;
    localparam int WN    = 4 * C;          // n . n
    localparam int WM    = 3 * C;          // |d|
    localparam int WPC   = 2 * (WM + 1);
    localparam int WSQ   = 6 * C;          // d^2
    localparam int WPD   = (WSQ + 1) + (WN + 1);
    localparam int WPR   = 10 * C;
    localparam int LM    = 4;              // multiplier latency
    localparam int NSTG  = 4 * LM + 5;

    logic            en;
    logic [NSTG-1:0] vld_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------ unpack
    logic signed [C-1:0]  pt  [3];
    logic signed [WO-1:0] aov [3];
    logic signed [WO-1:0] ev  [3][3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            pt[c]    = signed'(s_data.newest_point[c*C +: C]);
            aov[c]   = -(WO'(pt[c]));
            ev[0][c] = WO'(signed'(s_data.edge_ab[c*C +: C]));
            ev[1][c] = WO'(signed'(s_data.edge_ac[c*C +: C]));
            ev[2][c] = WO'(signed'(s_data.edge_ad[c*C +: C]));
        end
    end

    // ------------------------------------------------------------ round A
    logic signed [WPA-1:0] np_p [3][3];
    logic signed [WPA-1:0] np_q [3][3];
    logic signed [WPA-1:0] eop  [3][3];
    logic signed [WPA-1:0] sqp  [3][3];
    logic signed [WPA-1:0] xp   [3][3];

    for (genvar k = 0; k < 3; k++) begin : g_ra
        localparam int K2 = (k + 1) % 3;
        for (genvar c = 0; c < 3; c++) begin : g_c
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            gjk_css_smul #(.WA(WO), .WB(WO)) u_np (
                .aclk(aclk), .en(en), .a(ev[k][C1]), .b(ev[K2][C2]), .p(np_p[k][c]));
            gjk_css_smul #(.WA(WO), .WB(WO)) u_nq (
                .aclk(aclk), .en(en), .a(ev[k][C2]), .b(ev[K2][C1]), .p(np_q[k][c]));
            gjk_css_smul #(.WA(WO), .WB(WO)) u_eo (
                .aclk(aclk), .en(en), .a(ev[k][c]), .b(aov[c]), .p(eop[k][c]));
            gjk_css_smul #(.WA(WO), .WB(WO)) u_sq (
                .aclk(aclk), .en(en), .a(ev[k][c]), .b(ev[k][c]), .p(sqp[k][c]));
            gjk_css_smul #(.WA(WO), .WB(WO)) u_x (
                .aclk(aclk), .en(en), .a(ev[k][c]), .b(ev[K2][c]), .p(xp[k][c]));
        end
    end

    logic [KIND_W-1:0] kind_d;
    logic [3*WO-1:0]   ao_pk, ao_pk_d;

    assign ao_pk = {aov[2], aov[1], aov[0]};

    gjk_css_dly #(.W(KIND_W), .DEPTH(LM)) u_kind_dly (
        .aclk(aclk), .en(en), .d(s_data.simplex_kind), .q(kind_d));
    gjk_css_dly #(.W(3*WO), .DEPTH(LM+1)) u_ao_dly (
        .aclk(aclk), .en(en), .d(ao_pk), .q(ao_pk_d));

    // ------------------------------------------------------------ stage sums A
    logic signed [WD-1:0] n_reg  [3][3];
    logic signed [WD-1:0] n_next [3][3];
    logic signed [WD-1:0] eo_reg [3], eo_next [3];
    logic signed [WD-1:0] sq_reg [3], sq_next [3];
    logic signed [WD-1:0] x_reg  [3], x_next  [3];
    ctrl_t                ctrl_a_reg, ctrl_a_next;

    always_comb begin
        ctrl_a_next      = '0;
        ctrl_a_next.kind = kind_d;
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                n_next[k][c] = WD'(np_p[k][c] - np_q[k][c]);
            end
            eo_next[k] = WD'(eop[k][0] + eop[k][1] + eop[k][2]);
            sq_next[k] = WD'(sqp[k][0] + sqp[k][1] + sqp[k][2]);
            x_next[k]  = WD'(xp[k][0] + xp[k][1] + xp[k][2]);
            ctrl_a_next.eo_nn[k] = !eo_next[k][WD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg      <= n_next;
            eo_reg     <= eo_next;
            sq_reg     <= sq_next;
            x_reg      <= x_next;
            ctrl_a_reg <= ctrl_a_next;
        end
    end

    // ------------------------------------------------------------ round B
    logic signed [WO-1:0]   ao_b [3];
    logic signed [WPBD-1:0] dp   [3][3];
    logic signed [WPB-1:0]  nnp  [3][3];
    logic signed [WPB-1:0]  tm   [3][4];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ao_b[c] = signed'(ao_pk_d[c*WO +: WO]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_rb
        localparam int K2 = (k + 1) % 3;
        for (genvar c = 0; c < 3; c++) begin : g_c
            gjk_css_smul #(.WA(WD), .WB(WO)) u_d (
                .aclk(aclk), .en(en), .a(n_reg[k][c]), .b(ao_b[c]), .p(dp[k][c]));
            gjk_css_smul #(.WA(WD), .WB(WD)) u_nn (
                .aclk(aclk), .en(en), .a(n_reg[k][c]), .b(n_reg[k][c]), .p(nnp[k][c]));
        end
        // (n x e2).ao = (e1.e2)(e2.ao) - (e2.e2)(e1.ao)
        gjk_css_smul #(.WA(WD), .WB(WD)) u_t0 (
            .aclk(aclk), .en(en), .a(x_reg[k]), .b(eo_reg[K2]), .p(tm[k][0]));
        gjk_css_smul #(.WA(WD), .WB(WD)) u_t1 (
            .aclk(aclk), .en(en), .a(sq_reg[K2]), .b(eo_reg[k]), .p(tm[k][1]));
        // (e1 x n).ao = (e1.e2)(e1.ao) - (e1.e1)(e2.ao)
        gjk_css_smul #(.WA(WD), .WB(WD)) u_t2 (
            .aclk(aclk), .en(en), .a(x_reg[k]), .b(eo_reg[k]), .p(tm[k][2]));
        gjk_css_smul #(.WA(WD), .WB(WD)) u_t3 (
            .aclk(aclk), .en(en), .a(sq_reg[k]), .b(eo_reg[K2]), .p(tm[k][3]));
    end

    ctrl_t ctrl_b_d;

    gjk_css_dly #(.W($bits(ctrl_t)), .DEPTH(LM)) u_ctrl_b_dly (
        .aclk(aclk), .en(en), .d(ctrl_a_reg), .q(ctrl_b_d));

    // ------------------------------------------------------------ stage sums B
    logic signed [WDD-1:0] d_reg  [3], d_next  [3];
    logic [WN-1:0]         nn_reg [3], nn_next [3];
    logic signed [WPB-1:0] t1v [3], t2v [3];
    ctrl_t                 ctrl_b_reg, ctrl_b_next;

    always_comb begin
        ctrl_b_next = ctrl_b_d;
        for (int k = 0; k < 3; k++) begin
            d_next[k]  = WDD'(dp[k][0] + dp[k][1] + dp[k][2]);
            nn_next[k] = WN'(nnp[k][0] + nnp[k][1] + nnp[k][2]);
            t1v[k]     = tm[k][0] - tm[k][1];
            t2v[k]     = tm[k][2] - tm[k][3];
            ctrl_b_next.t1_nn[k] = !t1v[k][WPB-1];
            ctrl_b_next.t2_nn[k] = !t2v[k][WPB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg      <= d_next;
            nn_reg     <= nn_next;
            ctrl_b_reg <= ctrl_b_next;
        end
    end

    // ------------------------------------------------------------ magnitude stage
    logic [WM-1:0] dmag_reg [3], dmag_next [3];
    logic [WN-1:0] den_reg  [3], den_next  [3];
    ctrl_t         ctrl_c_reg, ctrl_c_next;

    always_comb begin
        ctrl_c_next = ctrl_b_reg;
        for (int k = 0; k < 3; k++) begin
            dmag_next[k] = d_reg[k][WDD-1] ? WM'(-d_reg[k]) : WM'(d_reg[k]);
            // zero normal means zero distance, so any nonzero denominator works
            den_next[k]  = (nn_reg[k] == '0) ? WN'(1) : nn_reg[k];
            ctrl_c_next.d_neg[k] = d_reg[k][WDD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg   <= dmag_next;
            den_reg    <= den_next;
            ctrl_c_reg <= ctrl_c_next;
        end
    end

    // ------------------------------------------------------------ round C: d squared
    logic signed [WPC-1:0] sqd [3];

    for (genvar k = 0; k < 3; k++) begin : g_rc
        gjk_css_smul #(.WA(WM+1), .WB(WM+1)) u_sqd (
            .aclk(aclk), .en(en), .a((WM+1)'(dmag_reg[k])), .b((WM+1)'(dmag_reg[k])),
            .p(sqd[k]));
    end

    logic [3*WN-1:0] den_pk, den_pk_d;
    ctrl_t           ctrl_d_d;

    assign den_pk = {den_reg[2], den_reg[1], den_reg[0]};

    gjk_css_dly #(.W(3*WN), .DEPTH(LM)) u_den_dly (
        .aclk(aclk), .en(en), .d(den_pk), .q(den_pk_d));
    gjk_css_dly #(.W($bits(ctrl_t)), .DEPTH(2*LM)) u_ctrl_d_dly (
        .aclk(aclk), .en(en), .d(ctrl_c_reg), .q(ctrl_d_d));

    // ------------------------------------------------------------ round D: cross products
    // pairs: abc/acd, abc/adb, acd/adb
    logic signed [WPD-1:0] fwd [3];
    logic signed [WPD-1:0] rev [3];

    for (genvar q = 0; q < 3; q++) begin : g_rd
        localparam int PA = (q == 2) ? 1 : 0;
        localparam int PB = (q == 0) ? 1 : 2;
        gjk_css_smul #(.WA(WSQ+1), .WB(WN+1)) u_fwd (
            .aclk(aclk), .en(en),
            .a((WSQ+1)'(sqd[PA][WSQ-1:0])), .b((WN+1)'(den_pk_d[PB*WN +: WN])),
            .p(fwd[q]));
        gjk_css_smul #(.WA(WSQ+1), .WB(WN+1)) u_rev (
            .aclk(aclk), .en(en),
            .a((WSQ+1)'(sqd[PB][WSQ-1:0])), .b((WN+1)'(den_pk_d[PA*WN +: WN])),
            .p(rev[q]));
    end

    // ------------------------------------------------------------ compare stage
    function automatic logic frac_gt(input logic sa, input logic [WPR-1:0] ma,
                                     input logic sb, input logic [WPR-1:0] mb);
        logic r;
        if (sa != sb) begin
            r = !sa;
        end else if (sa) begin
            r = ma < mb;
        end else begin
            r = ma > mb;
        end
        return r;
    endfunction

    ctrl_t ctrl_e_reg, ctrl_e_next;

    always_comb begin
        ctrl_e_next       = ctrl_d_d;
        ctrl_e_next.gt[0] = frac_gt(ctrl_d_d.d_neg[0], fwd[0][WPR-1:0],
                                    ctrl_d_d.d_neg[1], rev[0][WPR-1:0]);
        ctrl_e_next.gt[1] = frac_gt(ctrl_d_d.d_neg[0], fwd[1][WPR-1:0],
                                    ctrl_d_d.d_neg[2], rev[1][WPR-1:0]);
        ctrl_e_next.gt[2] = frac_gt(ctrl_d_d.d_neg[1], fwd[2][WPR-1:0],
                                    ctrl_d_d.d_neg[2], rev[2][WPR-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_e_reg <= ctrl_e_next;
        end
    end

    // ------------------------------------------------------------ decision stage
    out_beat_t out_reg, out_next;

    always_comb begin
        logic [1:0] pick;
        logic [1:0] ib, ic;
        logic       t1, t2, e1o, e2o;

        out_next = '0;

        if (ctrl_e_reg.gt[0] && ctrl_e_reg.gt[1]) begin
            pick = FACE_ABC;
        end else if (!ctrl_e_reg.gt[0] && ctrl_e_reg.gt[2]) begin
            pick = FACE_ACD;
        end else begin
            pick = FACE_ADB;
        end

        case (pick)
            FACE_ABC: begin ib = 2'd0; ic = 2'd1; end
            FACE_ACD: begin ib = 2'd1; ic = 2'd2; end
            default:  begin ib = 2'd2; ic = 2'd0; end
        endcase

        t1  = ctrl_e_reg.t1_nn[pick];
        t2  = ctrl_e_reg.t2_nn[pick];
        e1o = ctrl_e_reg.eo_nn[ib];
        e2o = ctrl_e_reg.eo_nn[ic];

        case (ctrl_e_reg.kind)
            KIND_SEGMENT: begin
                if (!ctrl_e_reg.eo_nn[0]) begin
                    out_next.kept_kind   = KEPT_POINT;
                    out_next.first_index = 2'd1;
                end
            end
            KIND_TRIANGLE: begin
                if (ctrl_e_reg.t1_nn[0]) begin
                    if (ctrl_e_reg.eo_nn[1]) begin
                        out_next.kept_kind    = KEPT_SEGMENT;
                        out_next.first_index  = 2'd1;
                        out_next.second_index = 2'd2;
                    end else if (ctrl_e_reg.eo_nn[0]) begin
                        out_next.kept_kind   = KEPT_SEGMENT;
                        out_next.first_index = 2'd2;
                    end else begin
                        out_next.kept_kind   = KEPT_POINT;
                        out_next.first_index = 2'd2;
                    end
                end else if (ctrl_e_reg.t2_nn[0]) begin
                    out_next.kept_kind   = ctrl_e_reg.eo_nn[0] ? KEPT_SEGMENT : KEPT_POINT;
                    out_next.first_index = 2'd2;
                end else if (ctrl_e_reg.d_neg[0]) begin
                    // origin below the face: keep it with flipped winding
                    out_next.kept_kind   = KEPT_TRIANGLE;
                    out_next.first_index = 2'd1;
                    out_next.third_index = 2'd2;
                end
            end
            KIND_TETRA: begin
                if (!ctrl_e_reg.d_neg[pick]) begin
                    if (t1) begin
                        if (e2o) begin
                            out_next.kept_kind    = KEPT_SEGMENT;
                            out_next.first_index  = ic;
                            out_next.second_index = 2'd3;
                        end else if (e1o) begin
                            out_next.kept_kind    = KEPT_SEGMENT;
                            out_next.first_index  = 2'd3;
                            out_next.second_index = ib;
                        end else begin
                            out_next.kept_kind   = KEPT_POINT;
                            out_next.first_index = 2'd3;
                        end
                    end else if (t2) begin
                        if (e1o) begin
                            out_next.kept_kind    = KEPT_SEGMENT;
                            out_next.first_index  = 2'd3;
                            out_next.second_index = ib;
                        end else begin
                            out_next.kept_kind   = KEPT_POINT;
                            out_next.first_index = 2'd3;
                        end
                    end else begin
                        out_next.kept_kind    = KEPT_TRIANGLE;
                        out_next.first_index  = ib;
                        out_next.second_index = ic;
                        out_next.third_index  = 2'd3;
                    end
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule
